### sv/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared widths, opcodes and saturation helpers for the running statistics unit.
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int SAMPLE_PORT_W = 16;  // in_sample port width
  localparam int SAMPLE_MAX_W  = 24;  // widest supported sample
  localparam int FRAC_W        = 16;  // fraction bits of mean / variance
  localparam int MEAN_W        = 32;
  localparam int DEV_W         = 42;  // scaled sample minus mean, signed
  localparam int ACC_W         = 44;  // mean plus step, before clamping
  localparam int MAG_W         = 32;  // clamped deviation magnitude
  localparam int PROD_W        = 2 * MAG_W;
  localparam int SUM_W         = 64;
  localparam int VAR_W         = 48;
  localparam int ROOT_W        = 32;
  localparam int RAD_W         = 2 * ROOT_W;
  localparam int COUNT_OUT_W   = 16;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Saturate to the signed 32-bit mean range.
  function automatic logic signed [MEAN_W-1:0] clamp_mean(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}});
    lo = $signed({{(ACC_W-MEAN_W+1){1'b1}}, {(MEAN_W-1){1'b0}}});
    if (v > hi) begin
      return $signed({1'b0, {(MEAN_W-1){1'b1}}});
    end else if (v < lo) begin
      return $signed({1'b1, {(MEAN_W-1){1'b0}}});
    end
    return v[MEAN_W-1:0];
  endfunction

  // Absolute value, clamped to 2^32 - 1.
  function automatic logic [MAG_W-1:0] dev_mag(input logic signed [DEV_W-1:0] d);
    logic [DEV_W-1:0] m;
    m = d[DEV_W-1] ? $unsigned(-d) : $unsigned(d);
    if (|m[DEV_W-1:MAG_W]) begin
      return {MAG_W{1'b1}};
    end
    return m[MAG_W-1:0];
  endfunction

endpackage

### sv/rmv_div.sv
// ----------------------------------------------------------------------------
// rmv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmv_div
  import rmv_pkg::*;
#(
  parameter int DIVIDEND_W = SUM_W,
  parameter int DIVISOR_W  = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff   = rem_sh - {1'b0, div_r};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/rmv_isqrt.sv
// ----------------------------------------------------------------------------
// rmv_isqrt
// Floor square root, digit by digit, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmv_isqrt
  import rmv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### sv/running_mean_variance_unit.sv
// ----------------------------------------------------------------------------
// running_mean_variance_unit
// Running count, mean, sample variance and standard deviation (Welford).
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is either a push of in_sample
// (in_operation = push) or a clear of the count. Every input beat gives
// exactly one result beat on the output channel (out_valid/out_ready) with
// the count, mean, variance, std dev and the count-saturated flag.
// Sequence: a clear or the first push after reset/clear goes straight to
// S_OUT and raises out_valid once the output register is free. Any other
// push runs a 64-step mean division, a multiply, a sum update, a 64-step
// variance division and a 32-step square root, plus the sequencer hops
// between them. The one divider is shared by both divisions, so the two
// divide passes take up most of the time.
// Throughput: one item at a time; in_ready is high only when the sequencer
// is idle. A finished result waits in the output register; the next item
// is taken meanwhile, but its own result is held until the first one is
// taken, so a stalled receiver stops the input once that second item is done.
// Reset (rst_n low, synchronous): count goes to zero, no result pending.
// ----------------------------------------------------------------------------
module running_mean_variance_unit
  import rmv_pkg::*;
#(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic signed [SAMPLE_PORT_W-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COUNT_OUT_W-1:0]          out_count,
  output logic signed [MEAN_W-1:0]        out_mean,
  output logic [VAR_W-1:0]                out_variance,
  output logic [ROOT_W-1:0]               out_std_dev,
  output logic                            out_count_saturated
);

  localparam int CNT_EXT_W = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,    // form x - mean, launch divide by n
    S_MEAN_WAIT,  // apply step to mean
    S_MUL,        // deviation product
    S_ACC,        // update sum of squared deviations
    S_VAR_GO,     // launch sum / (n - 1)
    S_VAR_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_OUT         // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // statistics state
  logic [COUNT_WIDTH-1:0]    count_r, count_nxt;
  logic signed [MEAN_W-1:0]  mean_r, mean_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;

  // per-item working registers
  logic signed [DEV_W-1:0]   xq_r, xq_nxt;
  logic [MAG_W-1:0]          mag1_r, mag1_nxt;
  logic                      d1_neg_r, d1_neg_nxt;
  logic                      d1_nz_r, d1_nz_nxt;
  logic                      term_neg_r, term_neg_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [VAR_W-1:0]          var_r, var_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [COUNT_OUT_W-1:0]    out_count_r, out_count_nxt;
  logic signed [MEAN_W-1:0]  out_mean_r, out_mean_nxt;
  logic [VAR_W-1:0]          out_var_r, out_var_nxt;
  logic [ROOT_W-1:0]         out_std_r, out_std_nxt;
  logic                      out_sat_r, out_sat_nxt;

  // input decode
  logic [SAMPLE_MAX_W-1:0]        smp_wide;
  logic signed [SAMPLE_WIDTH-1:0] x_raw;
  logic signed [DEV_W-1:0]        xq_in;
  logic [COUNT_WIDTH-1:0]         count_inc;

  // datapath
  logic signed [DEV_W-1:0]   d1;
  logic [DEV_W-1:0]          d1_abs;
  logic signed [DEV_W-1:0]   step_q;
  logic signed [ACC_W-1:0]   mean_sum;
  logic signed [DEV_W-1:0]   d2;
  logic [VAR_W-1:0]          term;
  logic [SUM_W:0]            sum_add;
  logic [CNT_EXT_W-1:0]      cnt_ext;

  // shared units
  logic                      div_start;
  logic [SUM_W-1:0]          div_dividend;
  logic [COUNT_WIDTH-1:0]    div_divisor;
  logic                      div_done;
  logic [SUM_W-1:0]          div_quo;
  logic                      sqrt_start;
  logic                      sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;

  // Only SAMPLE_WIDTH bits of the (zero-padded) port count, sign-extended.
  assign smp_wide = SAMPLE_MAX_W'($unsigned(in_sample));
  assign x_raw    = $signed(smp_wide[SAMPLE_WIDTH-1:0]);
  assign xq_in    = DEV_W'(x_raw) <<< FRAC_W;
  assign count_inc = (count_r != {COUNT_WIDTH{1'b1}}) ? count_r + 1'b1 : count_r;

  assign d1       = xq_r - DEV_W'(mean_r);
  assign d1_abs   = d1[DEV_W-1] ? $unsigned(-d1) : $unsigned(d1);
  // quotient magnitude is below 2^41, top bit of the slice is zero
  assign step_q   = d1_neg_r ? -$signed(div_quo[DEV_W-1:0]) : $signed(div_quo[DEV_W-1:0]);
  assign mean_sum = ACC_W'(mean_r) + ACC_W'(step_q);
  assign d2       = xq_r - DEV_W'(mean_r);
  assign term     = prod_r[PROD_W-1:FRAC_W];
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(term);
  assign cnt_ext  = CNT_EXT_W'(count_r);

  assign div_start    = (state_r == S_MEAN_GO) || (state_r == S_VAR_GO);
  assign div_dividend = (state_r == S_MEAN_GO) ? SUM_W'(d1_abs) : sum_r;
  assign div_divisor  = (state_r == S_MEAN_GO) ? count_r : count_r - 1'b1;
  assign sqrt_start   = (state_r == S_SQRT_GO);

  rmv_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  rmv_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({var_r, {FRAC_W{1'b0}}}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    sum_nxt       = sum_r;
    xq_nxt        = xq_r;
    mag1_nxt      = mag1_r;
    d1_neg_nxt    = d1_neg_r;
    d1_nz_nxt     = d1_nz_r;
    term_neg_nxt  = term_neg_r;
    prod_nxt      = prod_r;
    var_nxt       = var_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    out_mean_nxt  = out_mean_r;
    out_var_nxt   = out_var_r;
    out_std_nxt   = out_std_r;
    out_sat_nxt   = out_sat_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          xq_nxt   = xq_in;
          var_nxt  = '0;
          root_nxt = '0;
          if (op_t'(in_operation) == OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            count_nxt = count_inc;
            if (count_inc == COUNT_WIDTH'(1)) begin
              // first sample: mean takes it, sum restarts
              mean_nxt  = clamp_mean(ACC_W'(xq_in));
              sum_nxt   = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_MEAN_GO;
            end
          end
        end
      end
      S_MEAN_GO: begin
        mag1_nxt   = dev_mag(d1);
        d1_neg_nxt = d1[DEV_W-1];
        d1_nz_nxt  = (d1 != '0);
        state_nxt  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_done) begin
          mean_nxt  = clamp_mean(mean_sum);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // mean_r now holds the new mean
        prod_nxt     = PROD_W'(mag1_r) * PROD_W'(dev_mag(d2));
        term_neg_nxt = d1_nz_r && (d2 != '0) && (d1_neg_r != d2[DEV_W-1]);
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        if (term_neg_r) begin
          sum_nxt = (SUM_W'(term) > sum_r) ? '0 : sum_r - SUM_W'(term);
        end else begin
          sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        end
        state_nxt = S_VAR_GO;
      end
      S_VAR_GO: begin
        state_nxt = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (div_done) begin
          var_nxt   = (|div_quo[SUM_W-1:VAR_W]) ? {VAR_W{1'b1}} : div_quo[VAR_W-1:0];
          state_nxt = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        state_nxt = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          root_nxt  = sqrt_root;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = (cnt_ext > CNT_EXT_W'({COUNT_OUT_W{1'b1}})) ?
                          {COUNT_OUT_W{1'b1}} : cnt_ext[COUNT_OUT_W-1:0];
          out_mean_nxt  = (count_r == '0) ? '0 : mean_r;
          out_var_nxt   = var_r;
          out_std_nxt   = root_r;
          out_sat_nxt   = (count_r == {COUNT_WIDTH{1'b1}});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mean_r      <= mean_nxt;
    sum_r       <= sum_nxt;
    xq_r        <= xq_nxt;
    mag1_r      <= mag1_nxt;
    d1_neg_r    <= d1_neg_nxt;
    d1_nz_r     <= d1_nz_nxt;
    term_neg_r  <= term_neg_nxt;
    prod_r      <= prod_nxt;
    var_r       <= var_nxt;
    root_r      <= root_nxt;
    out_count_r <= out_count_nxt;
    out_mean_r  <= out_mean_nxt;
    out_var_r   <= out_var_nxt;
    out_std_r   <= out_std_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_count           = out_count_r;
  assign out_mean            = out_mean_r;
  assign out_variance        = out_var_r;
  assign out_std_dev         = out_std_r;
  assign out_count_saturated = out_sat_r;

endmodule

### sv/rmv_checker.sv
// ----------------------------------------------------------------------------
// rmv_checker
// Port-level checks for the running statistics unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmv_checker
  import rmv_pkg::*;
(
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [COUNT_OUT_W-1:0]          out_count,
  input logic signed [MEAN_W-1:0]        out_mean,
  input logic [VAR_W-1:0]                out_variance,
  input logic [ROOT_W-1:0]               out_std_dev,
  input logic                            out_count_saturated
);

  // stalled result beat holds its mean and variance
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_variance))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again without processing");

  // fewer than two samples: no spread
  a_low_count_zero_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count < 2 |-> out_variance == '0 && out_std_dev == '0)
    else $error("nonzero variance with count below two");

  // empty set reports zero mean and no saturation
  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == '0 |-> out_mean == '0 && !out_count_saturated)
    else $error("empty set reports mean or saturation");

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (.*);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for running_mean_variance_unit.
// ----------------------------------------------------------------------------
// A directed table of push and clear beats comes first. Then about 1200
// random beats run in three idle-mix phases, each followed by a full drain;
// a long receiver stall opens the last. A Welford predictor works out each
// untyped result; all are checked field by field against the result stream.
// ----------------------------------------------------------------------------
module tb_top;
  import rmv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Default count width; the limit sits at 65535 pushes.
  localparam int CNT_W = COUNT_WIDTH_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam longint unsigned VAR_LIMIT = (64'd1 << VAR_W) - 64'd1;
  localparam longint unsigned DEV_LIMIT = 64'h0000_0000_FFFF_FFFF;

  localparam int HOLD_CYCLES   = 1500;   // long receiver stall
  localparam int STUCK_LIMIT   = 20000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 400;    // longer than one full push
  localparam int N_DIRECTED    = 25;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0]   count;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [ROOT_W-1:0]        std_dev;
    logic                     saturated;
  } stats_t;

  typedef struct packed {
    op_t                     op;
    logic [SAMPLE_PORT_W-1:0] smp;
    logic                    typed;  // 1: want below is the expected result
    stats_t                  want;
  } row_t;

  localparam stats_t NO_EXP  = '0;
  localparam stats_t ZEROS   = '0;
  localparam stats_t FIRST_0 = '{16'd1, 32'sd0, 48'd0, 32'd0, 1'b0};
  localparam stats_t SECOND_0 = '{16'd2, 32'sd0, 48'd0, 32'd0, 1'b0};
  localparam stats_t FIRST_MIN = '{16'd1, 32'h8000_0000, 48'd0, 32'd0, 1'b0};
  localparam stats_t FIRST_MAX = '{16'd1, 32'sd2147418112, 48'd0, 32'd0, 1'b0};

  // Directed table. Clears, first pushes and the second push carry typed-in
  // results; the rest goes through the predictor. The last stretch is a run
  // of 16 pushes mixing extremes, sign flips and small steps, then a clear.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{OP_CLEAR, 16'h0000, 1'b1, ZEROS},     // right after reset
    '{OP_PUSH,  16'h0000, 1'b1, FIRST_0},
    '{OP_PUSH,  16'h0000, 1'b1, SECOND_0},
    '{OP_CLEAR, 16'h7FFF, 1'b1, ZEROS},     // sample ignored on clear
    '{OP_PUSH,  16'h8000, 1'b1, FIRST_MIN}, // most negative sample
    '{OP_PUSH,  16'h7FFF, 1'b0, NO_EXP},    // full-scale swing
    '{OP_PUSH,  16'h8000, 1'b0, NO_EXP},
    '{OP_CLEAR, 16'h8000, 1'b1, ZEROS},
    '{OP_PUSH,  16'h7FFF, 1'b1, FIRST_MAX},
    '{OP_PUSH,  16'h7FFF, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h0001, 1'b0, NO_EXP},
    '{OP_PUSH,  16'hFFFF, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h5555, 1'b0, NO_EXP},
    '{OP_PUSH,  16'hAAAA, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h0064, 1'b0, NO_EXP},
    '{OP_PUSH,  16'hFF9C, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h0007, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h8000, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h7FFF, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h0000, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h1234, 1'b0, NO_EXP},
    '{OP_PUSH,  16'hEDCC, 1'b0, NO_EXP},
    '{OP_PUSH,  16'h0100, 1'b0, NO_EXP},    // small step late in the run
    '{OP_PUSH,  16'h7FFF, 1'b0, NO_EXP},    // full scale late in the run
    '{OP_CLEAR, 16'h1234, 1'b1, ZEROS}      // clear after a long run
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_operation;
  logic signed [SAMPLE_PORT_W-1:0] in_sample;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [COUNT_OUT_W-1:0]          out_count;
  logic signed [MEAN_W-1:0]        out_mean;
  logic [VAR_W-1:0]                out_variance;
  logic [ROOT_W-1:0]               out_std_dev;
  logic                            out_count_saturated;

  running_mean_variance_unit #(
    .COUNT_WIDTH (CNT_W),
    .SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_count          (out_count),
    .out_mean           (out_mean),
    .out_variance       (out_variance),
    .out_std_dev        (out_std_dev),
    .out_count_saturated(out_count_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: count, mean (16 fraction bits), sum of squared deviations.
  longint unsigned tally;
  longint          mean_acc;
  longint unsigned sq_dev_sum;

  stats_t stats_q[$];      // expected results, oldest first
  int     mismatch_count = 0;
  int     push_beats;
  int     clear_beats;
  int     results_checked = 0;
  int     saturated_seen = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_token;      // bumped by the stimulus to start a receiver stall
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stuck_cycles = 0;
  logic [SAMPLE_PORT_W-1:0] last_sample;

  function automatic longint clip_mean(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned dev_abs(input longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : longint'(d);
    return (m > DEV_LIMIT) ? DEV_LIMIT : m;
  endfunction

  // Bitwise floor square root.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // One Welford step on the bench's own state; returns the result beat.
  function automatic stats_t welford_step(input op_t op, input logic [SAMPLE_PORT_W-1:0] smp);
    longint          xq;
    longint          old_mean;
    longint          new_mean;
    longint          d1;
    longint          d2;
    longint unsigned term;
    longint unsigned total;
    longint unsigned var_q;
    longint unsigned root;
    logic            neg;
    stats_t          r;
    var_q = 0;
    xq    = longint'($signed(smp)) * 64'sd65536;
    if (op == OP_CLEAR) begin
      tally = 0;  // mean and sum kept, overwritten by the next push
    end else begin
      if (tally < COUNT_MAX) tally++;
      if (tally == 1) begin
        mean_acc   = clip_mean(xq);
        sq_dev_sum = 0;
      end else begin
        old_mean = mean_acc;
        d1       = xq - old_mean;
        new_mean = clip_mean(old_mean + d1 / longint'(tally));
        d2       = xq - new_mean;
        term     = (dev_abs(d1) * dev_abs(d2)) >> FRAC_W;
        neg      = ((d1 < 0) != (d2 < 0)) && (d1 != 0) && (d2 != 0);
        if (neg) begin
          sq_dev_sum = (term > sq_dev_sum) ? 64'd0 : sq_dev_sum - term;
        end else begin
          total      = sq_dev_sum + term;
          sq_dev_sum = (total < sq_dev_sum) ? '1 : total;
        end
        mean_acc = new_mean;
      end
    end
    if (tally >= 2) begin
      var_q = sq_dev_sum / (tally - 1);
      if (var_q > VAR_LIMIT) var_q = VAR_LIMIT;
    end
    root        = floor_sqrt(var_q << FRAC_W);
    r.count     = (tally > 64'hFFFF) ? 16'hFFFF : tally[COUNT_OUT_W-1:0];
    r.mean      = (tally == 0) ? '0 : mean_acc[MEAN_W-1:0];
    r.variance  = var_q[VAR_W-1:0];
    r.std_dev   = root[ROOT_W-1:0];
    r.saturated = (tally == COUNT_MAX);
    return r;
  endfunction

  // Mix of full-range, small, extreme and slowly drifting samples, so both
  // large and tiny variances show up.
  function automatic logic [SAMPLE_PORT_W-1:0] pick_sample();
    int kind;
    int v;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: v = int'($urandom);
      4, 5:       v = int'($urandom_range(0, 63)) - 32;
      6:          v = $urandom_range(0, 1) ? 32'h8000 : 32'h7FFF;
      default:    v = int'($signed(last_sample)) + int'($urandom_range(0, 15)) - 8;
    endcase
    last_sample = v[SAMPLE_PORT_W-1:0];
    return last_sample;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
             $realtime, field, got, want, results_checked);
    mismatch_count++;
  endtask

  // Offer one input beat, with random idle cycles ahead of it. Valid stays
  // high across back-to-back beats; it only drops during an idle gap.
  task automatic send_beat(input op_t op, input logic [SAMPLE_PORT_W-1:0] smp,
                           input logic typed, input stats_t want);
    stats_t calc;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_sample    <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = welford_step(op, smp);
    stats_q.push_back(typed ? want : calc);
    if (op == OP_CLEAR) clear_beats++;
    else push_beats++;
  endtask

  // Sender goes quiet until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stats_q.size() != 0) @(posedge clk);
  endtask

  // Push runs of random length broken by clears; about one beat in twelve
  // is a clear, so runs average about a dozen pushes.
  task automatic run_random(input int n_beats);
    op_t op;
    for (int i = 0; i < n_beats; i++) begin
      op = ($urandom_range(0, 11) == 0) ? OP_CLEAR : OP_PUSH;
      send_beat(op, pick_sample(), 1'b0, NO_EXP);
    end
  endtask

  // Result side: check each beat, then decide out_ready for the next cycle.
  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_count, out_mean, out_variance, out_std_dev, out_count_saturated};
        if (stats_q.size() == 0) begin
          $display("[%0t] result beat with nothing expected", $realtime);
          mismatch_count++;
        end else begin
          want = stats_q.pop_front();
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
          if (got.mean !== want.mean)
            report_mismatch("mean", got.mean, want.mean);
          if (got.variance !== want.variance)
            report_mismatch("variance", got.variance, want.variance);
          if (got.std_dev !== want.std_dev)
            report_mismatch("std_dev", got.std_dev, want.std_dev);
          if (got.saturated !== want.saturated)
            report_mismatch("count_saturated", got.saturated, want.saturated);
          if (want.saturated) saturated_seen++;
        end
        results_checked++;
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any accepted beat on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d results outstanding",
               $realtime, STUCK_LIMIT, stats_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_PUSH;
    in_sample       = '0;
    tally           = 0;
    mean_acc        = 0;
    sq_dev_sum      = 0;
    push_beats      = 0;
    clear_beats     = 0;
    hold_token      = 0;
    last_sample     = '0;
    send_idle_pct   = 8;
    recv_idle_pct   = 59;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_beat(DIRECTED[i].op, DIRECTED[i].smp, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain_results();

    // Phase 1: sender mostly busy, receiver often stalled.
    run_random(400);
    drain_results();

    // Phase 2: roles swapped.
    send_idle_pct = 59;
    recv_idle_pct = 8;
    run_random(400);
    drain_results();

    // Phase 3: no idling; opens with a long receiver stall so the output
    // register fills, the next result backs up and in_ready drops.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_token++;
    run_random(425);
    drain_results();

    // Catch any stray result beat after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d push and %0d clear beats across directed, idle-mix and stall phases.",
             push_beats, clear_beats);
    $display("Checked %0d results, %0d of them at the count limit; %0d mismatches.",
             results_checked, saturated_seen, mismatch_count);
    if (mismatch_count == 0 && stats_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/rmv_pkg.sv
sv/rmv_div.sv
sv/rmv_isqrt.sv
sv/running_mean_variance_unit.sv
sv/rmv_checker.sv
tb/sv/tb_top.sv
